FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro expects clk and rst_n in scope; checks are off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge
`define ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

FILE: hdl/hwrl_pkg.sv
package hwrl_pkg;

    // Table geometry
    localparam int TABLE_INDEX_BITS = 10;
    localparam int TABLE_SIZE       = 1 << TABLE_INDEX_BITS;

    // Field widths
    localparam int HASH_W         = 32;
    localparam int TIME_W         = 32;
    localparam int COUNT_W        = 8;
    localparam int BYTE_W         = 8;
    localparam int BUCKET_INDEX_W = 10;
    localparam int WINDOW_W       = 16;
    localparam int IGNORE_W       = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    // Hash multiplier 31 is done as (h << 5) - h
    localparam int HASH_SHIFT = 5;

    // Job queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1);
    localparam logic [COUNT_W-1:0]  LIMIT_RESET  = COUNT_W'(5);
    localparam logic [IGNORE_W-1:0] IGNORE_RESET = IGNORE_W'(60);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_IGNORE = 2'd2
    } cfg_reg_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } back_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] name_byte;
        logic              name_end;
        logic [TIME_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic                      ignore_sender;
        logic [BUCKET_INDEX_W-1:0] bucket_index;
    } out_item_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_seconds;
        logic [COUNT_W-1:0]  message_limit;
        logic [IGNORE_W-1:0] ignore_seconds;
    } cfg_t;

    typedef struct packed {
        logic [TABLE_INDEX_BITS-1:0] index;
        logic [TIME_W-1:0]           now;
    } job_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [COUNT_W-1:0] count;
    } bucket_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: hdl/hashed_window_rate_limiter_core.sv
// Fixed-window rate limiter keyed by a hash of the sender name. Name bytes
// are taken one per beat, and the front end folds each into the running hash
// in the cycle it arrives. The beat marked name_end queues a bucket job; the
// back end reads the bucket table (separate read and write ports) through a
// registered read, then writes the update once the output register is free.
// Name bytes are taken until the job queue fills. After reset the table is
// cleared one bucket per cycle, all 1024 of them, during which in_ready
// stays low; configuration writes are taken at any time and should be made
// only while no name is in flight.
`include "assert_macros.svh"

module hashed_window_rate_limiter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  hwrl_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output hwrl_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [hwrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hwrl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hwrl_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    fifo_stat_t fifo_stat;
    job_t       push_job;
    job_t       head;
    logic       push;
    logic       pop;
    logic       clear_busy;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW: cfg_next.window_seconds = cfg_data[WINDOW_W-1:0];
                CFG_LIMIT:  cfg_next.message_limit  = cfg_data[COUNT_W-1:0];
                CFG_IGNORE: cfg_next.ignore_seconds = cfg_data[IGNORE_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_seconds <= WINDOW_RESET;
            cfg_reg.message_limit  <= LIMIT_RESET;
            cfg_reg.ignore_seconds <= IGNORE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hash front end
    hwrl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .clear_busy (clear_busy),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_job   (push_job)
    );

    // Job queue
    hwrl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    // Bucket table back end
    hwrl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_stat  (fifo_stat),
        .head       (head),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Checks
    `ASSERT_IMPL(a_no_accept_in_clear, clear_busy, !in_ready)
    `ASSERT_HOLDS(a_fifo_no_overflow, !(push && fifo_stat.full))
    `ASSERT_IMPL(a_pop_needs_data, pop, !fifo_stat.empty)
    `ASSERT_NEXT(a_end_is_queued, push, !fifo_stat.empty)

endmodule

FILE: hdl/hwrl_front.sv
module hwrl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hwrl_pkg::in_item_t   in_data,
    input  logic                 clear_busy,
    input  hwrl_pkg::fifo_stat_t fifo_stat,
    output logic                 push,
    output hwrl_pkg::job_t       push_job
);
    import hwrl_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] hash_mix;
    logic [HASH_W-1:0] byte_sext;
    logic              accept;

    // hash*31 + sign-extended byte
    assign byte_sext = {{(HASH_W-BYTE_W){in_data.name_byte[BYTE_W-1]}}, in_data.name_byte};
    assign hash_mix  = (hash_reg << HASH_SHIFT) - hash_reg + byte_sext;

    // Hold off bytes while the table clears or the queue is full
    assign in_ready = !clear_busy && !fifo_stat.full;
    assign accept   = in_valid && in_ready;

    // Name end hands a job to the back end
    assign push           = accept && in_data.name_end;
    assign push_job.index = hash_mix[TABLE_INDEX_BITS-1:0];
    assign push_job.now   = in_data.now_seconds;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = in_data.name_end ? '0 : hash_mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

FILE: hdl/hwrl_fifo.sv
module hwrl_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hwrl_pkg::job_t       push_job,
    input  logic                 pop,
    output hwrl_pkg::job_t       head,
    output hwrl_pkg::fifo_stat_t stat
);
    import hwrl_pkg::*;

    job_t                  entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: hdl/hwrl_back.sv
module hwrl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hwrl_pkg::cfg_t       cfg,
    input  hwrl_pkg::fifo_stat_t fifo_stat,
    input  hwrl_pkg::job_t       head,
    output logic                 pop,
    output logic                 clear_busy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hwrl_pkg::out_item_t  out_data
);
    import hwrl_pkg::*;

    // Bucket table: one write and one registered read per cycle
    bucket_t bucket_mem [TABLE_SIZE];

    back_state_t                 state_reg;
    back_state_t                 state_next;
    logic [TABLE_INDEX_BITS-1:0] clr_addr_reg;
    logic [TABLE_INDEX_BITS-1:0] clr_addr_next;
    job_t                        job_reg;
    job_t                        job_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    out_item_t                   out_data_reg;
    out_item_t                   out_data_next;
    bucket_t                     rd_data_reg;

    logic [TABLE_INDEX_BITS-1:0] rd_addr;
    logic [TABLE_INDEX_BITS-1:0] wr_addr;
    logic                        wr_en;
    bucket_t                     wr_data;

    logic [TIME_W-1:0]  diff;
    logic               restart;
    logic [COUNT_W:0]   cnt_inc;
    logic               over;
    logic               out_free;

    assign clear_busy = (state_reg == BK_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Address the queue head while idle, else the job in flight
    assign rd_addr = (state_reg == BK_IDLE) ? head.index : job_reg.index;

    // Window check on the bucket just read
    assign diff    = job_reg.now - rd_data_reg.stamp;
    assign restart = !diff[TIME_W-1] && (diff > TIME_W'(cfg.window_seconds));
    assign cnt_inc = {1'b0, rd_data_reg.count} + 1'b1;
    assign over    = (cnt_inc > {1'b0, cfg.message_limit});

    // Sequencer: clear pass, then pop / read / update per job
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = job_reg.index;
        wr_data        = '0;

        case (state_reg)
            BK_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == TABLE_INDEX_BITS'(TABLE_SIZE - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    job_next   = head;
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (out_free)
                begin
                    wr_en = 1'b1;
                    out_data_next.bucket_index = BUCKET_INDEX_W'(job_reg.index);
                    if (restart)
                    begin
                        wr_data.stamp = job_reg.now;
                        wr_data.count = COUNT_W'(1);
                        out_data_next.ignore_sender = 1'b0;
                    end
                    else if (over)
                    begin
                        wr_data.stamp = job_reg.now + TIME_W'(cfg.ignore_seconds);
                        wr_data.count = cfg.message_limit;
                        out_data_next.ignore_sender = 1'b1;
                    end
                    else
                    begin
                        wr_data.stamp = rd_data_reg.stamp;
                        wr_data.count = cnt_inc[COUNT_W-1:0];
                        out_data_next.ignore_sender = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_data_reg <= out_data_next;
    end

    // Table port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bucket_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= bucket_mem[rd_addr];
    end

endmodule

FILE: sim/tb_hashed_window_rate_limiter_core.sv
`timescale 1ns / 1ps

module tb_hashed_window_rate_limiter_core;
    import hwrl_pkg::*;

    localparam logic [HASH_W-1:0]      HASH_MULT      = 31;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam int                     POOL_NAMES     = 8;
    localparam int                     MAX_NAME       = 8;
    localparam int                     HOLD_CYCLES    = 400;
    localparam int                     WATCHDOG_LIMIT = 4000;
    localparam int                     DRAIN_CYCLES   = 8;
    localparam int                     HEAVY_PCT      = 77;
    localparam int                     MIXED_PCT      = 24;

    // Bucket predictor plus the queue of verdicts still owed by the block
    class flood_scoreboard;
        logic [WINDOW_W-1:0] window_s;
        logic [COUNT_W-1:0]  limit;
        logic [IGNORE_W-1:0] ignore_s;
        logic [HASH_W-1:0]   name_hash;
        logic [TIME_W-1:0]   bucket_stamp [TABLE_SIZE];
        logic [COUNT_W-1:0]  bucket_hits [TABLE_SIZE];
        out_item_t           verdicts [$];
        int                  mismatches;

        function new();
            window_s   = WINDOW_RESET;
            limit      = LIMIT_RESET;
            ignore_s   = IGNORE_RESET;
            name_hash  = '0;
            mismatches = 0;
            foreach (bucket_stamp[i])
            begin
                bucket_stamp[i] = '0;
                bucket_hits[i]  = '0;
            end
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WINDOW: window_s = val[WINDOW_W-1:0];
                CFG_LIMIT:  limit    = val[COUNT_W-1:0];
                CFG_IGNORE: ignore_s = val[IGNORE_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // Fold one name byte; the last byte runs the bucket check
        function void note_beat(in_item_t beat);
            logic [TABLE_INDEX_BITS-1:0] slot;
            logic [TIME_W-1:0]           age;
            logic [COUNT_W:0]            hits;
            out_item_t                   verdict;
            name_hash = HASH_W'(name_hash * HASH_MULT)
                      + {{(HASH_W-BYTE_W){beat.name_byte[BYTE_W-1]}}, beat.name_byte};
            if (!beat.name_end)
                return;
            slot      = name_hash[TABLE_INDEX_BITS-1:0];
            name_hash = '0;
            age       = beat.now_seconds - bucket_stamp[slot];
            verdict.ignore_sender = 1'b0;
            // negative age (stamp in the future) never restarts the window
            if (!age[TIME_W-1] && age > TIME_W'(window_s))
            begin
                bucket_stamp[slot] = beat.now_seconds;
                bucket_hits[slot]  = COUNT_W'(1);
            end
            else
            begin
                hits = {1'b0, bucket_hits[slot]} + 1'b1;
                if (hits > {1'b0, limit})
                begin
                    bucket_stamp[slot]    = beat.now_seconds + TIME_W'(ignore_s);
                    bucket_hits[slot]     = limit;
                    verdict.ignore_sender = 1'b1;
                end
                else
                    bucket_hits[slot] = hits[COUNT_W-1:0];
            end
            verdict.bucket_index = BUCKET_INDEX_W'(slot);
            verdicts.push_back(verdict);
        endfunction

        function void complain(string what);
            mismatches++;
            $display("%0t: %s", $time, what);
        endfunction

        function void check_verdict(out_item_t got);
            out_item_t want;
            if (verdicts.size() == 0)
            begin
                complain($sformatf("result beat with none expected: ignore=%0b bucket=%0d",
                                   got.ignore_sender, got.bucket_index));
                return;
            end
            want = verdicts.pop_front();
            if (got.ignore_sender !== want.ignore_sender)
                complain($sformatf("ignore_sender expected %0b actual %0b",
                                   want.ignore_sender, got.ignore_sender));
            if (got.bucket_index !== want.bucket_index)
                complain($sformatf("bucket_index expected %0d actual %0d",
                                   want.bucket_index, got.bucket_index));
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    flood_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    logic            pressure_on    = 1'b0;
    int              hold_count     = 0;
    int              quiet_cycles   = 0;
    logic [TIME_W-1:0] wall_clock   = '0;

    logic [BYTE_W-1:0] pool_bytes [POOL_NAMES][MAX_NAME];
    int                pool_len [POOL_NAMES];

    hashed_window_rate_limiter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: one long hold when pressure is requested, random stalls otherwise
    always @(posedge clk)
    begin
        if (pressure_on && hold_count < HOLD_CYCLES)
        begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Beat monitor and quiet-cycle counter
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_beat(in_data);
        if (out_valid && out_ready)
            sb.check_verdict(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic in_item_t beat_of(logic [BYTE_W-1:0] b, logic last,
                                         logic [TIME_W-1:0] stamp);
        in_item_t beat;
        beat.name_byte   = b;
        beat.name_end    = last;
        beat.now_seconds = stamp;
        return beat;
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input in_item_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [WINDOW_W-1:0] window_s,
                                 input logic [COUNT_W-1:0] limit,
                                 input logic [IGNORE_W-1:0] ignore_s);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        write_reg(CFG_WINDOW, window_s);
        write_reg(CFG_LIMIT, {8'($urandom()), limit});
        write_reg(CFG_IGNORE, ignore_s);
        cfg_we <= 1'b0;
    endtask

    // Wait for every owed verdict, then let the back end go quiet
    task automatic settle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly repeat senders from a small pool, with random names as noise
    task automatic random_names(input int n_beats, input int pool_size, input int max_len,
                                input int pool_pct, input bit steady);
        int                sent;
        int                pick;
        int                len;
        int                r;
        logic [BYTE_W-1:0] name [MAX_NAME];
        sent = 0;
        for (int p = 0; p < pool_size; p++)
        begin
            pool_len[p] = $urandom_range(max_len, 1);
            for (int k = 0; k < MAX_NAME; k++)
                pool_bytes[p][k] = BYTE_W'($urandom_range(255));
        end
        wall_clock = $urandom_range(1) ? TIME_W'($urandom()) : 32'hFFFF_FFF0;
        while (sent < n_beats)
        begin
            if ($urandom_range(99) < pool_pct)
            begin
                pick = $urandom_range(pool_size - 1);
                len  = pool_len[pick];
                for (int k = 0; k < MAX_NAME; k++)
                    name[k] = pool_bytes[pick][k];
            end
            else
            begin
                len = $urandom_range(max_len, 1);
                for (int k = 0; k < MAX_NAME; k++)
                    name[k] = BYTE_W'($urandom_range(255));
            end
            // time mostly creeps forward; sometimes stands, steps back or leaps
            if (!steady)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    wall_clock += $urandom_range(3);
                else if (r < 80)
                    wall_clock += 0;
                else if (r < 88)
                    wall_clock -= $urandom_range(100);
                else if (r < 96)
                    wall_clock += $urandom_range(70000);
                else
                    wall_clock = $urandom();
            end
            for (int k = 0; k < len; k++)
                send_beat(beat_of(name[k], k == len - 1,
                                  (k == len - 1) ? wall_clock : TIME_W'($urandom())));
            sent += len;
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // unmapped register index must not disturb the reset settings
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_we <= 1'b0;

        // Directed: flood on bucket 0, future stamp, window edge, sign-extended bytes
        for (int k = 0; k < 6; k++)
            send_beat(beat_of(8'h00, 1'b1, 32'd0));
        send_beat(beat_of(8'h00, 1'b1, 32'd10));
        send_beat(beat_of(8'h00, 1'b1, 32'd71));
        send_beat(beat_of(8'h00, 1'b1, 32'd133));
        send_beat(beat_of(8'hFF, 1'b1, 32'hFFFF_FFFF));
        send_beat(beat_of(8'h80, 1'b1, 32'h8000_0000));
        send_beat(beat_of(8'h7F, 1'b1, 32'h7FFF_FFFF));
        send_beat(beat_of(8'h41, 1'b0, 32'hFFFF_FFFF));
        send_beat(beat_of(8'hC3, 1'b0, 32'h0000_0000));
        send_beat(beat_of(8'h01, 1'b1, 32'd5));
        send_beat(beat_of(8'hFF, 1'b0, 32'hAAAA_AAAA));
        send_beat(beat_of(8'hFF, 1'b1, 32'h5555_5555));
        for (int k = 0; k < 4; k++)
            send_beat(beat_of(k[0] ? 8'h55 : 8'hAA, k == 3, 32'h1234_5678));
        in_valid <= 1'b0;
        settle();

        // Zero window, limit of one, zero ignore period
        load_settings(16'd0, 8'd1, 16'd0);
        random_names(160, 4, 6, 80, 1'b0);
        settle();

        // One sender hammering a frozen clock: count saturates at 255
        send_idle_pct = HEAVY_PCT;
        load_settings(16'hFFFF, 8'd255, 16'hFFFF);
        random_names(320, 1, 1, 100, 1'b1);
        settle();

        // Limit of zero: every hit past a restart is a flood
        send_idle_pct  = 0;
        recv_stall_pct = HEAVY_PCT;
        load_settings(WINDOW_W'($urandom()), 8'd0, IGNORE_W'($urandom()));
        random_names(200, 6, 5, 80, 1'b0);
        settle();

        send_idle_pct  = MIXED_PCT;
        recv_stall_pct = MIXED_PCT;
        load_settings(16'd3, 8'd4, 16'd10);
        random_names(250, 8, 8, 75, 1'b0);
        settle();

        // Receiver holds off while the sender keeps offering beats
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_settings(16'hFFFF, 8'd1, 16'd0);
        pressure_on <= 1'b1;
        random_names(200, 3, 3, 85, 1'b0);
        settle();

        load_settings(WINDOW_W'($urandom_range(20)), COUNT_W'($urandom_range(255, 1)),
                      IGNORE_W'($urandom()));
        random_names(300, 8, 6, 80, 1'b0);
        settle();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hwrl_pkg.sv
hdl/hwrl_front.sv
hdl/hwrl_fifo.sv
hdl/hwrl_back.sv
hdl/hashed_window_rate_limiter_core.sv
sim/tb_hashed_window_rate_limiter_core.sv
